### src/frb_pkg.sv
// Package for the fragment reassembly buffer.
// Sizes, header byte offsets, command and status codes, header helper.
// No dependencies.
package frb_pkg;

   localparam int BLOCK_BYTES  = 512;
   localparam int HEADER_BYTES = 10;
   localparam int MAX_BLOCKS   = 16;

   localparam int HDR_KEEP  = 10;
   localparam int SIZE_AT   = 0;
   localparam int PACKED_AT = 4;
   localparam int BLOCK_AT  = 8;
   localparam int LAST_AT   = 9;

   localparam int STORE_BYTES = MAX_BLOCKS * BLOCK_BYTES;
   localparam int FRAME_BYTES = HEADER_BYTES + BLOCK_BYTES;

   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int POS_W  = $clog2(FRAME_BYTES + 1);
   localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int HIDX_W = $clog2(HDR_KEEP);

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 13;
   localparam int LEN_W    = 14;
   localparam int STATUS_W = 3;

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_FRAGMENT = 2'd0;
   localparam cmd_type CMD_READ     = 2'd1;
   localparam cmd_type CMD_CLEAR    = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED    = 3'd0,
      ST_COMPLETE    = 3'd1,
      ST_NO_BLOCK0   = 3'd2,
      ST_ZERO_SIZE   = 3'd3,
      ST_ZERO_PACKED = 3'd4,
      ST_BAD_BLOCK   = 3'd5,
      ST_READ_DATA   = 3'd6
   } status_type;

   typedef logic [HDR_KEEP-1:0][BYTE_W-1:0] header_type;

   function automatic logic [31:0] be32(input header_type hdr, input int at);
      return {hdr[at], hdr[at+1], hdr[at+2], hdr[at+3]};
   endfunction

endpackage

### src/frb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module frb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fragment_reassembly_buffer.sv
// Fragment reassembly buffer top level.
// Uses frb_pkg and one frb_ram for the payload store.
//
// Usage:
//   req channel: one beat per command. cmd 0 carries one fragment byte (header
//   bytes first, then payload, frag_last on the final byte), cmd 1 reads one
//   byte of the completed message at read_index, cmd 2 drops all partial state.
//   rsp channel: exactly one beat per request beat, in order, with status,
//   message length and read data.
//   Each accepted request passes the RAM-read stage (payload RAM read), then
//   the output register, before response valid.
//   Throughput is one beat per cycle while rsp_stall is low; payload bytes
//   cost one RAM write and cmd 1 one RAM read, with header/bitmap updates in
//   flops.
//   When rsp_stall is held, the output register and the RAM-read stage fill
//   and req_stall rises; nothing is dropped.
//   Reset clears the bitmap, counters, header and length; the payload RAM is
//   not cleared and reading unwritten bytes returns unspecified data.
module fragment_reassembly_buffer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [frb_pkg::CMD_W-1:0]      req_cmd,
   input  logic [frb_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_frag_last,
   input  logic [frb_pkg::INDEX_W-1:0]    req_read_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [frb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [frb_pkg::LEN_W-1:0]      rsp_msg_length,
   output logic [frb_pkg::BYTE_W-1:0]     rsp_read_data
);

   logic [frb_pkg::MAX_BLOCKS-1:0] map_ff, map_in;
   logic [frb_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [frb_pkg::POS_W-1:0]      pos_ff, pos_in;
   frb_pkg::header_type            header_ff, header_in;
   logic [31:0]                    size_ff, size_in;
   logic [31:0]                    packed_ff, packed_in;
   logic [frb_pkg::LEN_W-1:0]      msg_len_ff, msg_len_in;

   logic                           s1_valid_ff;
   frb_pkg::status_type            s1_status_ff, s1_status_in;
   logic [frb_pkg::LEN_W-1:0]      s1_len_ff, s1_len_in;
   logic                           s1_hit_ff, s1_hit_in;

   logic                           rsp_valid_ff;
   frb_pkg::status_type            rsp_status_ff;
   logic [frb_pkg::LEN_W-1:0]      rsp_len_ff;
   logic [frb_pkg::BYTE_W-1:0]     rsp_data_ff;

   logic                           out_free;
   logic                           s1_go;
   logic                           accept;
   logic                           ram_wr_en;
   logic [frb_pkg::ADDR_W-1:0]     ram_wr_addr;
   logic                           ram_rd_en;
   logic [frb_pkg::ADDR_W-1:0]     ram_rd_addr;
   logic [frb_pkg::BYTE_W-1:0]     ram_rd_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      frb_pkg::header_type           hdr_upd;
      logic [frb_pkg::BYTE_W-1:0]    cur_block;
      logic [frb_pkg::BYTE_W-1:0]    new_block;
      logic [frb_pkg::BLK_W-1:0]     blk;
      logic [frb_pkg::MAX_BLOCKS-1:0] map_upd;
      logic [frb_pkg::CNT_W-1:0]     count_upd;
      logic [31:0]                   size_upd;
      logic [31:0]                   packed_upd;
      logic [31:0]                   cap;
      logic [31:0]                   len_full;
      logic [31:0]                   offset;

      map_in       = map_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      header_in    = header_ff;
      size_in      = size_ff;
      packed_in    = packed_ff;
      msg_len_in   = msg_len_ff;
      s1_status_in = frb_pkg::ST_ACCEPTED;
      s1_len_in    = '0;
      s1_hit_in    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = frb_pkg::ADDR_W'(req_read_index);

      hdr_upd = header_ff;
      if (int'(pos_ff) < frb_pkg::HDR_KEEP) begin
         hdr_upd[pos_ff[frb_pkg::HIDX_W-1:0]] = req_data_byte;
      end
      cur_block = header_ff[frb_pkg::BLOCK_AT];
      new_block = hdr_upd[frb_pkg::BLOCK_AT];
      blk       = frb_pkg::BLK_W'(new_block);
      offset    = 32'(pos_ff) - 32'(frb_pkg::HEADER_BYTES);
      ram_wr_addr = frb_pkg::ADDR_W'(32'(cur_block) * 32'(frb_pkg::BLOCK_BYTES) + offset);

      map_upd       = map_ff;
      map_upd[blk]  = 1'b1;
      count_upd     = count_ff + frb_pkg::CNT_W'(!map_ff[blk]);
      size_upd      = (new_block == '0) ? frb_pkg::be32(hdr_upd, frb_pkg::SIZE_AT) : size_ff;
      packed_upd    = (new_block == '0) ? frb_pkg::be32(hdr_upd, frb_pkg::PACKED_AT)
                                        : packed_ff;
      cap           = 32'(count_upd) * 32'(frb_pkg::BLOCK_BYTES);
      len_full      = (size_upd < cap) ? size_upd : cap;
      if (len_full > 32'(frb_pkg::STORE_BYTES)) begin
         len_full = 32'(frb_pkg::STORE_BYTES);
      end

      if (accept) begin
         unique case (req_cmd)
            frb_pkg::CMD_FRAGMENT: begin
               ram_wr_en = int'(pos_ff) >= frb_pkg::HEADER_BYTES &&
                           int'(pos_ff) < frb_pkg::FRAME_BYTES &&
                           int'(cur_block) < frb_pkg::MAX_BLOCKS;
               header_in = hdr_upd;
               if (int'(pos_ff) < frb_pkg::FRAME_BYTES) begin
                  pos_in = pos_ff + frb_pkg::POS_W'(1);
               end
               if (req_frag_last) begin
                  if (int'(new_block) >= frb_pkg::MAX_BLOCKS) begin
                     s1_status_in = frb_pkg::ST_BAD_BLOCK;
                  end else begin
                     map_in    = map_upd;
                     count_in  = count_upd;
                     size_in   = size_upd;
                     packed_in = packed_upd;
                     if (int'(count_upd) == int'(hdr_upd[frb_pkg::LAST_AT]) + 1) begin
                        priority if (!map_upd[0]) begin
                           s1_status_in = frb_pkg::ST_NO_BLOCK0;
                        end else if (size_upd == '0) begin
                           s1_status_in = frb_pkg::ST_ZERO_SIZE;
                        end else if (packed_upd == '0) begin
                           s1_status_in = frb_pkg::ST_ZERO_PACKED;
                        end else begin
                           s1_status_in = frb_pkg::ST_COMPLETE;
                           s1_len_in    = frb_pkg::LEN_W'(len_full);
                           msg_len_in   = frb_pkg::LEN_W'(len_full);
                        end
                        map_in    = '0;
                        count_in  = '0;
                        size_in   = '0;
                        packed_in = '0;
                     end
                  end
                  pos_in    = '0;
                  header_in = '0;
               end
            end
            frb_pkg::CMD_READ: begin
               ram_rd_en    = 1'b1;
               s1_status_in = frb_pkg::ST_READ_DATA;
               s1_len_in    = msg_len_ff;
               s1_hit_in    = ({1'b0, req_read_index} < msg_len_ff) &&
                              (32'(req_read_index) < 32'(frb_pkg::STORE_BYTES));
            end
            frb_pkg::CMD_CLEAR: begin
               map_in    = '0;
               count_in  = '0;
               size_in   = '0;
               packed_in = '0;
               pos_in    = '0;
               header_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   frb_ram #(
      .WIDTH (frb_pkg::BYTE_W),
      .DEPTH (frb_pkg::STORE_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         header_ff    <= '0;
         size_ff      <= '0;
         packed_ff    <= '0;
         msg_len_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff     <= map_in;
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         header_ff  <= header_in;
         size_ff    <= size_in;
         packed_ff  <= packed_in;
         msg_len_ff <= msg_len_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= s1_status_in;
         s1_len_ff    <= s1_len_in;
         s1_hit_ff    <= s1_hit_in;
      end
      if (s1_go) begin
         rsp_status_ff <= s1_status_ff;
         rsp_len_ff    <= s1_len_ff;
         rsp_data_ff   <= (s1_status_ff == frb_pkg::ST_READ_DATA && s1_hit_ff) ?
                          ram_rd_data : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_msg_length = rsp_len_ff;
   assign rsp_read_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(map_ff))
      else $error("received count differs from bitmap population");

   a_no_read_while_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !ram_rd_en)
      else $error("payload RAM read while its data stage is held");

   a_clear_drops_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == frb_pkg::CMD_CLEAR) |=>
      (map_ff == '0 && count_ff == '0 && pos_ff == '0))
      else $error("clear command left fragment state behind");

   a_len_only_when_used: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != frb_pkg::ST_COMPLETE &&
       rsp_status_ff != frb_pkg::ST_READ_DATA) |-> (rsp_len_ff == '0 && rsp_data_ff == '0))
      else $error("length or data on a status that carries neither");
`endif

endmodule
